/* rtl/core/mexp_pkg.sv */
`default_nettype none

package mexp_pkg;

  // Field widths
  localparam int ResBits  = 30;
  localparam int ExpBits  = 63;
  localparam int InBytes  = (ResBits + ExpBits + 7) / 8;
  localparam int OutBytes = (ResBits + 7) / 8;

  // Prime modulus
  localparam logic [ResBits-1:0] Prime = 30'd1000000007;

  // Multiplier digit slicing: one digit of the multiplier per cell
  localparam int DigitBits = 6;
  localparam int NumCells  = ResBits / DigitBits;

  // Partial sum inside a cell: acc * 2^DigitBits + digit * a < 2^(ResBits+DigitBits+1)
  localparam int SumBits  = ResBits + DigitBits + 1;
  // Quotient estimate from the top bits of the partial sum
  localparam int QShift   = ResBits - 1;
  localparam int TopBits  = SumBits - QShift;
  localparam int QBits    = DigitBits + 1;
  localparam int QEntries = 1 << TopBits;

  // Round counter
  localparam int RoundBits = (ExpBits > 1) ? $clog2(ExpBits) : 1;

  typedef logic [QBits-1:0] qtbl_t [QEntries];

  // floor(t * 2^QShift / Prime): never above the true quotient, at most one below
  function automatic qtbl_t build_qtbl();
    qtbl_t tbl;
    for (int i = 0; i < QEntries; i++) begin
      tbl[i] = QBits'((64'(i) << QShift) / 64'(Prime));
    end
    return tbl;
  endfunction

  localparam qtbl_t QTbl = build_qtbl();

  // Kind of product in flight
  typedef enum logic {
    TAG_SQ,
    TAG_ACC
  } tag_e;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ,
    ST_MUL,
    ST_WAIT,
    ST_DONE
  } state_e;

  // Product request into the chain
  typedef struct packed {
    logic               valid;
    tag_e               tag;
    logic [ResBits-1:0] a;
    logic [ResBits-1:0] b;
  } op_t;

  // Data handed from cell to cell
  typedef struct packed {
    logic               valid;
    tag_e               tag;
    logic [ResBits-1:0] acc;
    logic [ResBits-1:0] a;
    logic [ResBits-1:0] b;
  } stage_t;

  // Finished product out of the chain
  typedef struct packed {
    logic               valid;
    tag_e               tag;
    logic [ResBits-1:0] value;
  } res_t;

endpackage

`default_nettype wire

/* rtl/core/mexp_cell.sv */
`default_nettype none

module mexp_cell (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire mexp_pkg::stage_t stage_i,
  output mexp_pkg::stage_t     stage_o
);

  logic [mexp_pkg::DigitBits-1:0] digit;
  logic [mexp_pkg::SumBits-2:0]   prod;
  logic [mexp_pkg::SumBits-1:0]   sum;
  logic [mexp_pkg::TopBits-1:0]   top;
  logic [mexp_pkg::QBits-1:0]     qest;
  logic [mexp_pkg::SumBits-1:0]   qp;
  logic [mexp_pkg::ResBits:0]     rem;
  logic [mexp_pkg::ResBits-1:0]   acc_d;

  logic                           valid_q;
  mexp_pkg::tag_e                 tag_q;
  logic [mexp_pkg::ResBits-1:0]   acc_q;
  logic [mexp_pkg::ResBits-1:0]   a_q;
  logic [mexp_pkg::ResBits-1:0]   b_q;

  // acc * 2^d + digit * a, then reduce by table quotient and one correction
  always_comb begin
    digit = stage_i.b[mexp_pkg::ResBits-1 -: mexp_pkg::DigitBits];
    prod  = digit * stage_i.a;
    sum   = {1'b0, stage_i.acc, {mexp_pkg::DigitBits{1'b0}}}
          + {1'b0, prod};
    top   = sum[mexp_pkg::SumBits-1:mexp_pkg::QShift];
    qest  = mexp_pkg::QTbl[top];
    qp    = mexp_pkg::SumBits'(qest) * mexp_pkg::SumBits'(mexp_pkg::Prime);
    rem   = (mexp_pkg::ResBits+1)'(sum - qp);
    if (rem >= {1'b0, mexp_pkg::Prime}) begin
      acc_d = mexp_pkg::ResBits'(rem - {1'b0, mexp_pkg::Prime});
    end else begin
      acc_d = rem[mexp_pkg::ResBits-1:0];
    end
  end

  // Valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= stage_i.valid;
    end
  end

  // Payload handed to the next cell
  always_ff @(posedge clk_i) begin
    tag_q <= stage_i.tag;
    acc_q <= acc_d;
    a_q   <= stage_i.a;
    b_q   <= stage_i.b << mexp_pkg::DigitBits;
  end

  always_comb begin
    stage_o.valid = valid_q;
    stage_o.tag   = tag_q;
    stage_o.acc   = acc_q;
    stage_o.a     = a_q;
    stage_o.b     = b_q;
  end

endmodule

`default_nettype wire

/* rtl/core/mexp_chain.sv */
`default_nettype none

module mexp_chain (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire mexp_pkg::op_t op_i,
  output mexp_pkg::res_t    res_o
);

  mexp_pkg::stage_t links [mexp_pkg::NumCells+1];

  // Chain head: partial product starts at zero
  always_comb begin
    links[0].valid = op_i.valid;
    links[0].tag   = op_i.tag;
    links[0].acc   = '0;
    links[0].a     = op_i.a;
    links[0].b     = op_i.b;
  end

  // One cell per multiplier digit, most significant digit first
  for (genvar k = 0; k < mexp_pkg::NumCells; k++) begin : g_cell
    mexp_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .stage_i (links[k]),
      .stage_o (links[k+1])
    );
  end

  // Chain tail
  always_comb begin
    res_o.valid = links[mexp_pkg::NumCells].valid;
    res_o.tag   = links[mexp_pkg::NumCells].tag;
    res_o.value = links[mexp_pkg::NumCells].acc;
  end

endmodule

`default_nettype wire

/* rtl/core/mexp_ctrl.sv */
`default_nettype none

module mexp_ctrl (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [mexp_pkg::ResBits-1:0]  base_i,
  input  wire logic [mexp_pkg::ExpBits-1:0]  exponent_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [mexp_pkg::ResBits-1:0]       power_residue_o,
  output mexp_pkg::op_t                      op_o,
  input  wire mexp_pkg::res_t                res_i
);

  mexp_pkg::state_e state_q, state_d;

  logic [mexp_pkg::ResBits-1:0]   sq_q;
  logic [mexp_pkg::ResBits-1:0]   acc_q;
  logic [mexp_pkg::ExpBits-1:0]   exp_q;
  logic [mexp_pkg::RoundBits-1:0] round_q;
  logic                           out_valid_q;
  logic [mexp_pkg::ResBits-1:0]   out_data_q;

  logic                           in_fire;
  logic                           out_load;
  logic                           round_end;
  logic                           last_round;
  logic [mexp_pkg::ResBits-1:0]   base_red;

  assign in_fire    = in_valid_i && in_ready_o;
  assign round_end  = res_i.valid && (res_i.tag == mexp_pkg::TAG_ACC);
  assign last_round = (round_q == mexp_pkg::RoundBits'(mexp_pkg::ExpBits - 1));

  // Base below 2^30 is under twice the prime: one subtract reduces it
  assign base_red = (base_i >= mexp_pkg::Prime) ? (base_i - mexp_pkg::Prime) : base_i;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mexp_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = mexp_pkg::ST_SQ;
      end
      mexp_pkg::ST_SQ: begin
        state_d = mexp_pkg::ST_MUL;
      end
      mexp_pkg::ST_MUL: begin
        state_d = mexp_pkg::ST_WAIT;
      end
      mexp_pkg::ST_WAIT: begin
        if (round_end) begin
          state_d = last_round ? mexp_pkg::ST_DONE : mexp_pkg::ST_SQ;
        end
      end
      mexp_pkg::ST_DONE: begin
        if (!out_valid_q || out_ready_i) state_d = mexp_pkg::ST_IDLE;
      end
      default: state_d = mexp_pkg::ST_IDLE;
    endcase
  end

  // Outputs: handshake and product requests
  always_comb begin
    in_ready_o = 1'b0;
    out_load   = 1'b0;
    op_o.valid = 1'b0;
    op_o.tag   = mexp_pkg::TAG_SQ;
    op_o.a     = sq_q;
    op_o.b     = sq_q;
    unique case (state_q)
      mexp_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
      end
      mexp_pkg::ST_SQ: begin
        op_o.valid = 1'b1;
      end
      mexp_pkg::ST_MUL: begin
        // Multiply by one keeps the accumulator when the bit is clear
        op_o.valid = 1'b1;
        op_o.tag   = mexp_pkg::TAG_ACC;
        op_o.a     = acc_q;
        op_o.b     = exp_q[0] ? sq_q : mexp_pkg::ResBits'(1);
      end
      mexp_pkg::ST_WAIT: begin
      end
      mexp_pkg::ST_DONE: begin
        out_load = !out_valid_q || out_ready_i;
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mexp_pkg::ST_IDLE;
      round_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_fire) begin
        round_q <= '0;
      end else if (state_q == mexp_pkg::ST_WAIT && round_end && !last_round) begin
        round_q <= round_q + mexp_pkg::RoundBits'(1);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working values: square, accumulator, exponent bits
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      sq_q  <= base_red;
      acc_q <= mexp_pkg::ResBits'(1);
      exp_q <= exponent_i;
    end else begin
      if (res_i.valid && res_i.tag == mexp_pkg::TAG_SQ) begin
        sq_q <= res_i.value;
      end
      if (round_end) begin
        acc_q <= res_i.value;
        exp_q <= exp_q >> 1;
      end
    end
    if (out_load) begin
      out_data_q <= acc_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign power_residue_o = out_data_q;

endmodule

`default_nettype wire

/* rtl/core/modular_exponentiation_unit.sv */
// Modular exponentiation modulo the prime 1000000007. Each input transaction
// carries a base and an exponent; one output transaction returns
// base^exponent mod 1000000007, with a base at or above the prime reduced
// first and an exponent of zero giving 1. Exponent bits are scanned from the
// least significant end, one square-and-multiply round per bit. Both
// products of a round go through a five-cell multiplier chain, one 6-bit
// digit of the multiplier per cell with the modular reduction done inside
// each cell; the next round starts only when the accumulator product of the
// round has left the chain. One item is worked on at a time. The finished
// result sits in an output register, so the next item is accepted while it
// waits to be taken.

`default_nettype none

module modular_exponentiation_unit (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // s_axis_tdata_i: [29:0] base, [92:30] exponent, [95:93] zero
  input  wire logic                               s_axis_tvalid_i,
  output logic                                    s_axis_tready_o,
  input  wire logic [mexp_pkg::InBytes*8-1:0]     s_axis_tdata_i,
  // m_axis_tdata_o: [29:0] power_residue, [31:30] zero
  output logic                                    m_axis_tvalid_o,
  input  wire logic                               m_axis_tready_i,
  output logic [mexp_pkg::OutBytes*8-1:0]         m_axis_tdata_o
);

  mexp_pkg::op_t                op;
  mexp_pkg::res_t               res;
  logic [mexp_pkg::ResBits-1:0] power_residue;

  // Sequencer with the working registers and output register
  mexp_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (s_axis_tvalid_i),
    .in_ready_o      (s_axis_tready_o),
    .base_i          (s_axis_tdata_i[mexp_pkg::ResBits-1:0]),
    .exponent_i      (s_axis_tdata_i[mexp_pkg::ResBits +: mexp_pkg::ExpBits]),
    .out_valid_o     (m_axis_tvalid_o),
    .out_ready_i     (m_axis_tready_i),
    .power_residue_o (power_residue),
    .op_o            (op),
    .res_i           (res)
  );

  // Modular multiplier as a chain of digit cells
  mexp_chain u_chain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .op_i   (op),
    .res_o  (res)
  );

  assign m_axis_tdata_o = (mexp_pkg::OutBytes*8)'(power_residue);

endmodule

`default_nettype wire
